/* hw/rtl/gregorian_date_add_days_assert.svh */
// assertion helpers for the checker file
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// same-cycle implication
`define GDAD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gdad_pkg.sv */
package gdad_pkg;

   localparam int YEAR_W     = 14;
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int ADD_W      = 16;
   localparam int SERIAL_W   = 23;
   localparam int CENT_W     = 8;
   localparam int ERA_W      = 6;
   localparam int DOE_W      = 18;
   localparam int Q1460_W    = 7;
   localparam int YOE_W      = 9;
   localparam int DOY_W      = 9;
   localparam int MP_W       = 4;
   localparam int YEAR_EXT_W = 15;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   // pipeline stage numbering
   localparam int NSTAGES   = 10;
   localparam int ST_IN     = 0;
   localparam int ST_CLAMP  = 1;
   localparam int ST_SERIAL = 2;
   localparam int ST_ERA    = 3;
   localparam int ST_DOE    = 4;
   localparam int ST_Q1460  = 5;
   localparam int ST_YOE    = 6;
   localparam int ST_DOY    = 7;
   localparam int ST_MP     = 8;
   localparam int ST_OUT    = 9;

   // reciprocal constants for division by constants
   localparam logic [12:0]         DIV100_MUL  = 13'd5243;    // shift 19
   localparam logic [22:0]         DIV_ERA_MUL = 23'd7525902; // shift 40
   localparam logic [17:0]         DIV1460_MUL = 18'd183860;  // shift 28
   localparam logic [17:0]         DIV365_MUL  = 18'd183860;  // shift 26
   localparam logic [12:0]         DIV153_MUL  = 13'd6854;    // shift 20

   localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 23'd365;
   localparam logic [DOE_W-1:0]    ERA_DAYS      = 18'd146097;
   localparam logic [DOE_W-1:0]    CENT_DAYS_1   = 18'd36524;
   localparam logic [DOE_W-1:0]    CENT_DAYS_2   = 18'd73048;
   localparam logic [DOE_W-1:0]    CENT_DAYS_3   = 18'd109572;
   localparam logic [DOE_W-1:0]    ERA_LAST_DAY  = 18'd146096;
   localparam logic [SERIAL_W-1:0] SERIAL_LIMIT  = 23'd3652424;
   localparam logic [SERIAL_W-1:0] MARCH_BIAS    = 23'd146037;
   localparam logic [YEAR_EXT_W-1:0] ERA_YEARS   = 15'd400;

   localparam logic [MONTH_W-1:0]  MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC = 4'd12;
   localparam logic [MP_W-1:0]     MP_JAN    = 4'd10;
   localparam logic [YEAR_W-1:0]   MAX_YEAR  = 14'd9999;
   localparam logic [DAY_W-1:0]    MAX_DAY   = 5'd31;

   typedef struct packed {
      logic [NSTAGES-1:0] load;
      logic [NSTAGES-1:0] valid;
   } pipe_ctl_type;

   // days before the first of a month in a common year
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
      case (month)
         4'd1:    month_start = 9'd0;
         4'd2:    month_start = 9'd31;
         4'd3:    month_start = 9'd59;
         4'd4:    month_start = 9'd90;
         4'd5:    month_start = 9'd120;
         4'd6:    month_start = 9'd151;
         4'd7:    month_start = 9'd181;
         4'd8:    month_start = 9'd212;
         4'd9:    month_start = 9'd243;
         4'd10:   month_start = 9'd273;
         4'd11:   month_start = 9'd304;
         4'd12:   month_start = 9'd334;
         default: month_start = 9'd0;
      endcase
   endfunction

   // days before the first of a month in a year that starts in march
   function automatic logic [8:0] march_start(input logic [MP_W-1:0] mp);
      case (mp)
         4'd0:    march_start = 9'd0;
         4'd1:    march_start = 9'd31;
         4'd2:    march_start = 9'd61;
         4'd3:    march_start = 9'd92;
         4'd4:    march_start = 9'd122;
         4'd5:    march_start = 9'd153;
         4'd6:    march_start = 9'd184;
         4'd7:    march_start = 9'd214;
         4'd8:    march_start = 9'd245;
         4'd9:    march_start = 9'd275;
         4'd10:   march_start = 9'd306;
         4'd11:   march_start = 9'd337;
         default: march_start = 9'd0;
      endcase
   endfunction

endpackage

/* hw/rtl/gregorian_date_add_days.sv */
// Adds a day count of 0 to 65535 to a proleptic Gregorian date and returns the
// resulting date. A month of zero reads as January, one above twelve as
// December, a day of zero as day 1, and a day past the end of its month rolls
// on into the next. A result past 9999-12-31 comes back as 9999-12-31 with the
// overflow flag in rsp_tuser set. The block takes one beat per cycle while
// the output is not stalled, and each result is presented in the output
// register after it has passed the ten register stages of the pipeline: the
// request register, the month and day clamp, the serial day sum and seven
// steps of the serial day to date conversion. A stalled output holds its beat
// while empty stages further up keep filling.
module gregorian_date_add_days (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_year, start_month, start_day, add_days, zero pad
   input  logic [gdad_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // end_year, end_month, end_day, zero pad
   output logic [gdad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // overflow
   output logic                              rsp_tuser
);
   import gdad_pkg::*;

   pipe_ctl_type        ctl;
   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [DAY_W-1:0]    day_ff;
   logic [ADD_W-1:0]    add_ff;
   logic [SERIAL_W-1:0] serial;
   logic                serial_overflow;
   logic [YEAR_W-1:0]   end_year;
   logic [MONTH_W-1:0]  end_month;
   logic [DAY_W-1:0]    end_day;
   logic                end_overflow;

   gdad_pipe_ctl u_pipe_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .ctl       (ctl)
   );

   always_ff @(posedge clock) begin
      if (ctl.load[ST_IN]) begin
         year_ff  <= req_tdata[13:0];
         month_ff <= req_tdata[17:14];
         day_ff   <= req_tdata[22:18];
         add_ff   <= req_tdata[38:23];
      end
   end

   gdad_to_serial u_to_serial (
      .clock    (clock),
      .ctl      (ctl),
      .in_year  (year_ff),
      .in_month (month_ff),
      .in_day   (day_ff),
      .in_add   (add_ff),
      .serial   (serial),
      .overflow (serial_overflow)
   );

   gdad_from_serial u_from_serial (
      .clock        (clock),
      .ctl          (ctl),
      .serial       (serial),
      .overflow     (serial_overflow),
      .end_year     (end_year),
      .end_month    (end_month),
      .end_day      (end_day),
      .end_overflow (end_overflow)
   );

   assign req_tready = ctl.load[ST_IN];
   assign rsp_tvalid = ctl.valid[ST_OUT];
   assign rsp_tdata  = {1'b0, end_day, end_month, end_year};
   assign rsp_tuser  = end_overflow;

endmodule

/* hw/rtl/gdad_pipe_ctl.sv */
module gdad_pipe_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   out_ready,
   output gdad_pkg::pipe_ctl_type ctl
);
   import gdad_pkg::*;

   logic [NSTAGES-1:0] valid_ff;
   logic [NSTAGES-1:0] valid_in;
   logic [NSTAGES-1:0] load;

   // a stage loads when it is empty or its successor loads
   always_comb begin
      load[NSTAGES-1] = !valid_ff[NSTAGES-1] || out_ready;
      for (int i = NSTAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NSTAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl = '{load: load, valid: valid_ff};

endmodule

/* hw/rtl/gdad_to_serial.sv */
module gdad_to_serial (
   input  logic                            clock,
   input  gdad_pkg::pipe_ctl_type          ctl,
   input  logic [gdad_pkg::YEAR_W-1:0]     in_year,
   input  logic [gdad_pkg::MONTH_W-1:0]    in_month,
   input  logic [gdad_pkg::DAY_W-1:0]      in_day,
   input  logic [gdad_pkg::ADD_W-1:0]      in_add,
   output logic [gdad_pkg::SERIAL_W-1:0]   serial,
   output logic                            overflow
);
   import gdad_pkg::*;

   // clamp stage
   logic [26:0]         prod100;
   logic [CENT_W-1:0]   cent_in;
   logic [MONTH_W-1:0]  month_in;
   logic [DAY_W-1:0]    day_in;
   logic [YEAR_W-1:0]   year_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [DAY_W-1:0]    day_ff;
   logic [ADD_W-1:0]    add_ff;
   logic [CENT_W-1:0]   cent_ff;

   // serial stage
   logic [YEAR_W-1:0]   cent_x100;
   logic                rem_nz;
   logic                leap;
   logic [CENT_W-1:0]   cent_up;
   logic [YEAR_W:0]     quad_sum;
   logic [CENT_W:0]     c400_sum;
   logic [SERIAL_W-1:0] serial_in;
   logic                overflow_in;
   logic [SERIAL_W-1:0] serial_ff;
   logic                overflow_ff;

   assign prod100 = {13'd0, in_year} * {14'd0, DIV100_MUL};
   assign cent_in = prod100[26:19];

   always_comb begin
      if (in_month < MONTH_JAN) begin
         month_in = MONTH_JAN;
      end else if (in_month > MONTH_DEC) begin
         month_in = MONTH_DEC;
      end else begin
         month_in = in_month;
      end
      day_in = (in_day == '0) ? DAY_W'(1) : in_day;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_CLAMP]) begin
         year_ff  <= in_year;
         month_ff <= month_in;
         day_ff   <= day_in;
         add_ff   <= in_add;
         cent_ff  <= cent_in;
      end
   end

   // leap test and days before the start of the year
   assign cent_x100 = {6'd0, cent_ff} * 14'd100;
   assign rem_nz    = (year_ff != cent_x100);
   assign leap      = (year_ff[1:0] == 2'b00) && (rem_nz || (cent_ff[1:0] == 2'b00));
   assign cent_up   = cent_ff + {{(CENT_W-1){1'b0}}, rem_nz};
   assign quad_sum  = {1'b0, year_ff} + 15'd3;
   assign c400_sum  = {1'b0, cent_up} + 9'd3;

   always_comb begin
      serial_in = SERIAL_W'(year_ff) * DAYS_PER_YEAR
                + SERIAL_W'(quad_sum[YEAR_W:2])
                - SERIAL_W'(cent_up)
                + SERIAL_W'(c400_sum[CENT_W:2])
                + SERIAL_W'(month_start(month_ff))
                + SERIAL_W'(leap && (month_ff > MONTH_FEB))
                + SERIAL_W'(day_ff) - SERIAL_W'(1)
                + SERIAL_W'(add_ff);
      overflow_in = (serial_in > SERIAL_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_SERIAL]) begin
         serial_ff   <= serial_in;
         overflow_ff <= overflow_in;
      end
   end

   assign serial   = serial_ff;
   assign overflow = overflow_ff;

endmodule

/* hw/rtl/gdad_from_serial.sv */
module gdad_from_serial (
   input  logic                           clock,
   input  gdad_pkg::pipe_ctl_type         ctl,
   input  logic [gdad_pkg::SERIAL_W-1:0]  serial,
   input  logic                           overflow,
   output logic [gdad_pkg::YEAR_W-1:0]    end_year,
   output logic [gdad_pkg::MONTH_W-1:0]   end_month,
   output logic [gdad_pkg::DAY_W-1:0]     end_day,
   output logic                           end_overflow
);
   import gdad_pkg::*;

   // era stage
   logic [SERIAL_W-1:0]   z_in;
   logic [2*SERIAL_W-1:0] era_prod;
   logic [SERIAL_W-1:0]   z_ff;
   logic [ERA_W-1:0]      era3_ff;
   logic                  ovf3_ff;

   // day of era stage
   logic [SERIAL_W:0]     era_days;
   logic [SERIAL_W:0]     doe_full;
   logic [DOE_W-1:0]      doe4_ff;
   logic [ERA_W-1:0]      era4_ff;
   logic                  ovf4_ff;

   // four-year cycle stage
   logic [2*DOE_W-1:0]    p1460;
   logic [DOE_W-1:0]      doe5_ff;
   logic [Q1460_W-1:0]    q5_ff;
   logic [ERA_W-1:0]      era5_ff;
   logic                  ovf5_ff;

   // year of era stage
   logic [2:0]            cent_cnt;
   logic [DOE_W-1:0]      num;
   logic [2*DOE_W-1:0]    p365;
   logic [YOE_W-1:0]      yoe6_ff;
   logic [DOE_W-1:0]      doe6_ff;
   logic [ERA_W-1:0]      era6_ff;
   logic                  ovf6_ff;

   // day of year stage
   logic [1:0]            ycent;
   logic [DOE_W-1:0]      yoe_days;
   logic [DOE_W-1:0]      doy_full;
   logic [YEAR_EXT_W-1:0] year_in;
   logic [DOY_W-1:0]      doy7_ff;
   logic [YEAR_EXT_W-1:0] year7_ff;
   logic                  ovf7_ff;

   // month stage
   logic [10:0]           mnum;
   logic [23:0]           mp_prod;
   logic [MP_W-1:0]       mp8_ff;
   logic [DOY_W-1:0]      doy8_ff;
   logic [YEAR_EXT_W-1:0] year8_ff;
   logic                  ovf8_ff;

   // result stage
   logic [DOY_W-1:0]      day_full;
   logic [YEAR_EXT_W-1:0] year_full;
   logic [YEAR_W-1:0]     year_out_in;
   logic [MONTH_W-1:0]    month_out_in;
   logic [DAY_W-1:0]      day_out_in;
   logic [YEAR_W-1:0]     end_year_ff;
   logic [MONTH_W-1:0]    end_month_ff;
   logic [DAY_W-1:0]      end_day_ff;
   logic                  end_overflow_ff;

   // days counted from the first of march of year minus 400
   assign z_in     = serial + MARCH_BIAS;
   assign era_prod = {{SERIAL_W{1'b0}}, z_in} * {{SERIAL_W{1'b0}}, DIV_ERA_MUL};

   always_ff @(posedge clock) begin
      if (ctl.load[ST_ERA]) begin
         z_ff    <= z_in;
         era3_ff <= era_prod[45:40];
         ovf3_ff <= overflow;
      end
   end

   assign era_days = {18'd0, era3_ff} * {6'd0, ERA_DAYS};
   assign doe_full = {1'b0, z_ff} - era_days;

   always_ff @(posedge clock) begin
      if (ctl.load[ST_DOE]) begin
         doe4_ff <= doe_full[DOE_W-1:0];
         era4_ff <= era3_ff;
         ovf4_ff <= ovf3_ff;
      end
   end

   assign p1460 = {{DOE_W{1'b0}}, doe4_ff} * {{DOE_W{1'b0}}, DIV1460_MUL};

   always_ff @(posedge clock) begin
      if (ctl.load[ST_Q1460]) begin
         doe5_ff <= doe4_ff;
         q5_ff   <= p1460[34:28];
         era5_ff <= era4_ff;
         ovf5_ff <= ovf4_ff;
      end
   end

   always_comb begin
      cent_cnt = {2'b00, doe5_ff >= CENT_DAYS_1} + {2'b00, doe5_ff >= CENT_DAYS_2}
               + {2'b00, doe5_ff >= CENT_DAYS_3} + {2'b00, doe5_ff >= ERA_LAST_DAY};
      num      = doe5_ff - DOE_W'(q5_ff) + DOE_W'(cent_cnt)
               - DOE_W'(doe5_ff == ERA_LAST_DAY);
   end

   assign p365 = {{DOE_W{1'b0}}, num} * {{DOE_W{1'b0}}, DIV365_MUL};

   always_ff @(posedge clock) begin
      if (ctl.load[ST_YOE]) begin
         yoe6_ff <= p365[34:26];
         doe6_ff <= doe5_ff;
         era6_ff <= era5_ff;
         ovf6_ff <= ovf5_ff;
      end
   end

   always_comb begin
      ycent    = {1'b0, yoe6_ff >= 9'd100} + {1'b0, yoe6_ff >= 9'd200}
               + {1'b0, yoe6_ff >= 9'd300};
      yoe_days = DOE_W'(yoe6_ff) * DOE_W'(DAYS_PER_YEAR)
               + DOE_W'(yoe6_ff[YOE_W-1:2]) - DOE_W'(ycent);
      doy_full = doe6_ff - yoe_days;
      year_in  = YEAR_EXT_W'(era6_ff) * ERA_YEARS + YEAR_EXT_W'(yoe6_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_DOY]) begin
         doy7_ff  <= doy_full[DOY_W-1:0];
         year7_ff <= year_in;
         ovf7_ff  <= ovf6_ff;
      end
   end

   assign mnum    = {2'b00, doy7_ff} * 11'd5 + 11'd2;
   assign mp_prod = {13'd0, mnum} * {11'd0, DIV153_MUL};

   always_ff @(posedge clock) begin
      if (ctl.load[ST_MP]) begin
         mp8_ff   <= mp_prod[23:20];
         doy8_ff  <= doy7_ff;
         year8_ff <= year7_ff;
         ovf8_ff  <= ovf7_ff;
      end
   end

   always_comb begin
      day_full  = doy8_ff - march_start(mp8_ff) + DOY_W'(1);
      year_full = year8_ff + YEAR_EXT_W'(mp8_ff >= MP_JAN) - ERA_YEARS;
      if (ovf8_ff) begin
         year_out_in  = MAX_YEAR;
         month_out_in = MONTH_DEC;
         day_out_in   = MAX_DAY;
      end else begin
         year_out_in  = year_full[YEAR_W-1:0];
         month_out_in = (mp8_ff < MP_JAN) ? (mp8_ff + 4'd3) : (mp8_ff - 4'd9);
         day_out_in   = day_full[DAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_OUT]) begin
         end_year_ff     <= year_out_in;
         end_month_ff    <= month_out_in;
         end_day_ff      <= day_out_in;
         end_overflow_ff <= ovf8_ff;
      end
   end

   assign end_year     = end_year_ff;
   assign end_month    = end_month_ff;
   assign end_day      = end_day_ff;
   assign end_overflow = end_overflow_ff;

endmodule

/* hw/rtl/gdad_checker.sv */
`include "gregorian_date_add_days_assert.svh"

module gdad_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [gdad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);
   import gdad_pkg::*;

   logic                  rsp_stall;
   logic                  rsp_saturated;
   logic                  rsp_date_ok;
   logic [RSP_DATA_W:0]   rsp_beat;

   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_beat      = {rsp_tuser, rsp_tdata};
   assign rsp_saturated = (rsp_tdata[13:0] == MAX_YEAR) && (rsp_tdata[17:14] == MONTH_DEC)
                       && (rsp_tdata[22:18] == MAX_DAY);
   assign rsp_date_ok   = (rsp_tdata[13:0] <= MAX_YEAR) && (rsp_tdata[17:14] >= MONTH_JAN)
                       && (rsp_tdata[17:14] <= MONTH_DEC) && (rsp_tdata[22:18] != '0);

   `GDAD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                     rsp_tvalid && $stable(rsp_beat), "stalled response beat changed")
   `GDAD_ASSERT_SAME(a_overflow_saturates, clock, reset, rsp_tvalid && rsp_tuser,
                     rsp_saturated, "overflow beat not saturated to last date")
   `GDAD_ASSERT_SAME(a_date_in_range, clock, reset, rsp_tvalid && !rsp_tuser,
                     rsp_date_ok, "response date out of range")
   `GDAD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset,
                     !rsp_tvalid && req_tready, "pipeline not empty right after reset")

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
